// ----- rtl/temh_pkg.sv -----
`default_nettype none
package temh_pkg;
   localparam int HeapDepth = 64;
   localparam int AddrW = 6;
   localparam int CountW = 7;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ACCEPT  = 3'd0,
      KIND_DROPPED = 3'd1,
      KIND_RELEASE = 3'd2,
      KIND_IDLE    = 3'd3,
      KIND_CLEARED = 3'd4
   } kind_type;

   typedef struct packed {
      logic [31:0] t;
      logic [7:0]  prio;
      logic [31:0] payload;
   } entry_type;

   // wrap-safe ordering: a before b
   function automatic logic earlier(input entry_type a, input entry_type b);
      logic [31:0] dt;
      begin
         dt = a.t - b.t;
         if (dt != 32'd0) earlier = dt[31];
         else earlier = a.prio < b.prio;
      end
   endfunction
endpackage
`default_nettype wire

// ----- rtl/temh_req_if.sv -----
`default_nettype none
interface temh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [1:0]  num_events;
   logic [31:0] time_a;
   logic [7:0]  prio_a;
   logic [31:0] payload_a;
   logic [31:0] time_b;
   logic [7:0]  prio_b;
   logic [31:0] payload_b;
   logic [31:0] now_time;
   modport source (output valid, cmd, num_events, time_a, prio_a, payload_a,
                   time_b, prio_b, payload_b, now_time, input ready);
   modport sink (input valid, cmd, num_events, time_a, prio_a, payload_a,
                 time_b, prio_b, payload_b, now_time, output ready);
endinterface
`default_nettype wire

// ----- rtl/temh_rsp_if.sv -----
`default_nettype none
interface temh_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] out_time;
   logic [7:0]  out_prio;
   logic [31:0] out_payload;
   logic [6:0]  pending;
   logic        last;
   modport source (output valid, kind, out_time, out_prio, out_payload, pending, last,
                   input ready);
   modport sink (input valid, kind, out_time, out_prio, out_payload, pending, last,
                 output ready);
endinterface
`default_nettype wire

// ----- rtl/timed_event_min_heap.sv -----
// Push: each event passes S_INS, then S_UPRD and S_UPCMP for each level it rises,
// until it is written. Clear answers from idle, with its response in the next cycle.
// Tick: S_TOP makes each due check; a popped event passes S_DNL, then S_DNR and
// S_DNCMP per level sifted, then S_EMIT, and goes out at the next due check, which
// stalls while the response register waits. One request at a time, taken only when
// idle and the response register is free. Reset: synchronous, clears count/control.
`default_nettype none
module timed_event_min_heap
   import temh_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   temh_req_if.sink req,
   temh_rsp_if.source rsp
);
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_INS   = 9'b000000010,
      S_UPRD  = 9'b000000100,
      S_UPCMP = 9'b000001000,
      S_TOP   = 9'b000010000,
      S_DNL   = 9'b000100000,
      S_DNR   = 9'b001000000,
      S_DNCMP = 9'b010000000,
      S_EMIT  = 9'b100000000
   } state_type;

   entry_type mem [HeapDepth];
   entry_type rdata_ff;

   state_type state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [AddrW-1:0] idx_ff, idx_in, m_ff, m_in;
   entry_type cur_ff, cur_in, best_ff, best_in, second_ff, second_in;
   entry_type pop_ff, pop_in;
   logic [31:0] now_ff, now_in;
   logic two_ff, two_in, hasr_ff, hasr_in, held_ff, held_in;
   logic [AddrW-1:0] raddr;
   logic we;
   logic [AddrW-1:0] waddr;
   entry_type wdata;

   logic ov_ff, ov_in;
   kind_type okind_ff, okind_in;
   entry_type oent_ff, oent_in;
   logic [CountW-1:0] opend_ff, opend_in;
   logic olast_ff, olast_in;

   logic [CountW:0] need;
   logic [CountW+1:0] lidx, ridx;
   entry_type req_a, req_b;
   entry_type cmp_x, cmp_y;
   logic cmp_lt;
   logic [31:0] dt_now;
   logic due;

   assign req_a = '{t: req.time_a, prio: req.prio_a, payload: req.payload_a};
   assign req_b = '{t: req.time_b, prio: req.prio_b, payload: req.payload_b};
   assign need = {1'b0, count_ff} + ((req.num_events == 2'd0) ? (CountW+1)'(0) :
                 (req.num_events == 2'd1) ? (CountW+1)'(1) : (CountW+1)'(2));
   assign lidx = {2'b0, idx_ff, 1'b0} + (CountW+2)'(1);
   assign ridx = {2'b0, idx_ff, 1'b0} + (CountW+2)'(2);
   assign req.ready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp.valid = ov_ff;
   assign rsp.kind = okind_ff;
   assign rsp.out_time = oent_ff.t;
   assign rsp.out_prio = oent_ff.prio;
   assign rsp.out_payload = oent_ff.payload;
   assign rsp.pending = opend_ff;
   assign rsp.last = olast_ff;

   // one shared compare unit for sift-up and sift-down
   assign cmp_x = (state_ff == S_UPCMP) ? cur_ff : rdata_ff;
   assign cmp_y = (state_ff == S_UPCMP) ? rdata_ff : best_ff;
   assign cmp_lt = earlier(cmp_x, cmp_y);

   // root is due when the wrapped time difference is not negative
   assign dt_now = now_ff - rdata_ff.t;
   assign due = (count_ff != '0) && !dt_now[31];

   // heap memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   // sequence the sift steps
   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; m_in = m_ff;
      cur_in = cur_ff; best_in = best_ff; second_in = second_ff; now_in = now_ff;
      two_in = two_ff; hasr_in = hasr_ff; held_in = held_ff; pop_in = pop_ff;
      raddr = '0; we = 1'b0; waddr = idx_ff; wdata = cur_ff;
      ov_in = ov_ff && !rsp.ready; okind_in = okind_ff; oent_in = oent_ff;
      opend_in = opend_ff; olast_in = olast_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               okind_in = KIND_ACCEPT; oent_in = '0; olast_in = 1'b1;
               case (cmd_type'(req.cmd))
                  CMD_PUSH: begin
                     if (need > (CountW+1)'(HeapDepth)) begin
                        ov_in = 1'b1; okind_in = KIND_DROPPED; opend_in = count_ff;
                     end else if (req.num_events == 2'd0) begin
                        ov_in = 1'b1; opend_in = count_ff;
                     end else begin
                        cur_in = req_a; second_in = req_b;
                        two_in = req.num_events != 2'd1;
                        state_in = S_INS;
                     end
                  end
                  CMD_TICK: begin
                     now_in = req.now_time; raddr = '0; held_in = 1'b0;
                     if (count_ff == '0) begin
                        ov_in = 1'b1; okind_in = KIND_IDLE; opend_in = count_ff;
                     end else state_in = S_TOP;
                  end
                  CMD_CLEAR: begin
                     count_in = '0; ov_in = 1'b1; okind_in = KIND_CLEARED; opend_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_INS: begin
            // start sift-up at the new tail
            idx_in = count_ff[AddrW-1:0];
            state_in = S_UPRD;
         end
         S_UPRD: begin
            if (idx_ff == '0) begin
               we = 1'b1; count_in = count_ff + 1'b1;
               if (two_ff) begin
                  two_in = 1'b0; cur_in = second_ff; state_in = S_INS;
               end else begin
                  ov_in = 1'b1; opend_in = count_ff + 1'b1; state_in = S_IDLE;
               end
            end else begin
               raddr = (idx_ff - 1'b1) >> 1;
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            // move parent down while the new entry is earlier
            if (cmp_lt) begin
               we = 1'b1; wdata = rdata_ff;
               idx_in = (idx_ff - 1'b1) >> 1;
               state_in = S_UPRD;
            end else begin
               idx_in = '0;
               we = 1'b1; count_in = count_ff + 1'b1;
               if (two_ff) begin
                  two_in = 1'b0; cur_in = second_ff; state_in = S_INS;
               end else begin
                  ov_in = 1'b1; opend_in = count_ff + 1'b1; state_in = S_IDLE;
               end
            end
         end
         S_TOP: begin
            // root is in rdata; hold while a popped entry cannot go out
            if (!held_ff || !ov_ff || rsp.ready) begin
               if (held_ff) begin
                  ov_in = 1'b1; okind_in = KIND_RELEASE; oent_in = pop_ff;
                  opend_in = count_ff; olast_in = !due;
               end
               if (!due) begin
                  state_in = S_IDLE; held_in = 1'b0;
                  if (!held_ff) begin
                     ov_in = 1'b1; okind_in = KIND_IDLE; oent_in = '0;
                     opend_in = count_ff; olast_in = 1'b1;
                  end
               end else begin
                  pop_in = rdata_ff; held_in = 1'b1;
                  count_in = count_ff - 1'b1;
                  raddr = AddrW'(count_ff - 1'b1);
                  idx_in = '0;
                  state_in = S_DNL;
               end
            end
         end
         S_DNL: begin
            // tail entry arrives; fetch left child
            cur_in = rdata_ff;
            best_in = rdata_ff; m_in = idx_ff;
            if (count_ff == '0 || lidx >= (CountW+2)'(count_ff)) begin
               state_in = S_EMIT;
               if (count_ff != '0) begin we = 1'b1; wdata = rdata_ff; end
            end else begin
               raddr = lidx[AddrW-1:0];
               state_in = S_DNR;
            end
         end
         S_DNR: begin
            if (cmp_lt) begin
               best_in = rdata_ff; m_in = lidx[AddrW-1:0];
            end
            hasr_in = ridx < (CountW+2)'(count_ff);
            raddr = ridx[AddrW-1:0];
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            best_in = best_ff; m_in = m_ff;
            if (hasr_ff && cmp_lt) begin
               best_in = rdata_ff; m_in = ridx[AddrW-1:0];
            end
            if (m_in == idx_ff) begin
               we = 1'b1; state_in = S_EMIT;
            end else begin
               // child moves up, continue from its slot
               we = 1'b1; wdata = best_in; idx_in = m_in;
               best_in = cur_ff; m_in = m_in;
               if ({m_in, 1'b0} + (AddrW+1)'(1) >= (AddrW+1)'(count_ff) ||
                   m_in >= AddrW'(HeapDepth/2)) begin
                  state_in = S_EMIT;
               end else begin
                  raddr = AddrW'({m_in, 1'b0} + (AddrW+1)'(1));
                  state_in = S_DNR;
               end
            end
         end
         S_EMIT: begin
            // place the moved entry, then recheck the root
            we = 1'b1;
            raddr = '0;
            state_in = S_TOP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; ov_ff <= 1'b0; two_ff <= 1'b0;
         held_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ov_ff <= ov_in; two_ff <= two_in;
         held_ff <= held_in;
      end
      idx_ff <= idx_in; m_ff <= m_in; cur_ff <= cur_in; best_ff <= best_in;
      second_ff <= second_in; now_ff <= now_in; hasr_ff <= hasr_in;
      pop_ff <= pop_in;
      okind_ff <= okind_in; oent_ff <= oent_in; opend_ff <= opend_in;
      olast_ff <= olast_in;
   end
endmodule
`default_nettype wire

// ----- rtl/temh_checker.sv -----
`default_nettype none
module temh_checker
   import temh_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [2:0] rsp_kind,
   input wire logic [6:0] rsp_pending,
   input wire logic rsp_last
);
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_CLEARED |-> rsp_pending == 7'd0 && rsp_last)
      else $error("clear response not empty");
   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pending <= 7'(HeapDepth))
      else $error("pending above depth");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response waits");
endmodule

bind timed_event_min_heap temh_checker u_temh_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_kind(rsp.kind), .rsp_pending(rsp.pending), .rsp_last(rsp.last)
);
`default_nettype wire

// ----- tb/timed_event_min_heap_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module timed_event_min_heap_tb;
   import temh_pkg::*;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] t;
      logic [7:0]  prio;
      logic [31:0] payload;
      logic [6:0]  pending;
      logic        last;
   } outcome_type;

   // Timer-queue predictor and store of expected outcomes
   class heap_scoreboard;
      logic [31:0] h_time [HeapDepth];
      logic [7:0]  h_prio [HeapDepth];
      logic [31:0] h_pay [HeapDepth];
      int unsigned n_held;
      outcome_type due_q[$];
      int errors;

      function new();
         n_held = 0;
         errors = 0;
      endfunction

      function bit ahead(int i, int j);
         logic [31:0] dt;
         dt = h_time[i] - h_time[j];
         if (dt != 0) return dt[31];
         return h_prio[i] < h_prio[j];
      endfunction

      function void swap(int i, int j);
         logic [31:0] t;
         logic [7:0]  p;
         logic [31:0] d;
         t = h_time[i]; p = h_prio[i]; d = h_pay[i];
         h_time[i] = h_time[j]; h_prio[i] = h_prio[j]; h_pay[i] = h_pay[j];
         h_time[j] = t; h_prio[j] = p; h_pay[j] = d;
      endfunction

      function void insert(logic [31:0] t, logic [7:0] p, logic [31:0] d);
         int i;
         int up;
         i = n_held;
         h_time[i] = t; h_prio[i] = p; h_pay[i] = d;
         while (i > 0) begin
            up = (i - 1) / 2;
            if (!ahead(i, up)) break;
            swap(i, up);
            i = up;
         end
         n_held++;
      endfunction

      function void sink_root();
         int i;
         int l;
         int r;
         int m;
         i = 0;
         forever begin
            l = 2 * i + 1; r = 2 * i + 2; m = i;
            if (l < n_held && ahead(l, m)) m = l;
            if (r < n_held && ahead(r, m)) m = r;
            if (m == i) break;
            swap(i, m);
            i = m;
         end
      endfunction

      function void add(logic [2:0] k, logic [31:0] t, logic [7:0] p, logic [31:0] d,
                        logic lst);
         outcome_type o;
         o.kind = k; o.t = t; o.prio = p; o.payload = d;
         o.pending = n_held[6:0]; o.last = lst;
         due_q.push_back(o);
      endfunction

      // note an accepted request and queue its outcomes
      function void note_request(logic [1:0] cmd, logic [1:0] cnt,
                                 logic [31:0] ta, logic [7:0] pa, logic [31:0] da,
                                 logic [31:0] tb, logic [7:0] pb, logic [31:0] db,
                                 logic [31:0] now);
         int n;
         int k;
         logic [31:0] t;
         logic [31:0] dd;
         logic [7:0]  p;
         case (cmd)
            CMD_PUSH: begin
               n = (cnt > 2) ? 2 : cnt;
               if (n_held + n > HeapDepth) begin
                  add(KIND_DROPPED, 0, 0, 0, 1);
               end else begin
                  if (n >= 1) insert(ta, pa, da);
                  if (n >= 2) insert(tb, pb, db);
                  add(KIND_ACCEPT, 0, 0, 0, 1);
               end
            end
            CMD_TICK: begin
               k = 0;
               while (n_held > 0 && !((now - h_time[0]) >> 31)) begin
                  t = h_time[0]; p = h_prio[0]; dd = h_pay[0];
                  n_held--;
                  if (n_held > 0) begin
                     h_time[0] = h_time[n_held];
                     h_prio[0] = h_prio[n_held];
                     h_pay[0] = h_pay[n_held];
                     sink_root();
                  end
                  add(KIND_RELEASE, t, p, dd, 0);
                  k++;
               end
               if (k == 0) add(KIND_IDLE, 0, 0, 0, 1);
               else due_q[$].last = 1;
            end
            CMD_CLEAR: begin
               n_held = 0;
               add(KIND_CLEARED, 0, 0, 0, 1);
            end
            default: ;
         endcase
      endfunction

      // compare one result with the oldest expectation
      function void check_outcome(outcome_type got);
         outcome_type exp;
         if (due_q.size() == 0) begin
            $display("%0t: unexpected response actual=%h", $time, got);
            errors++;
            return;
         end
         exp = due_q.pop_front();
         if (got.kind !== exp.kind)
            $display("%0t: kind expected=%0d actual=%0d", $time, exp.kind, got.kind);
         if (got.t !== exp.t)
            $display("%0t: out_time expected=%h actual=%h", $time, exp.t, got.t);
         if (got.prio !== exp.prio)
            $display("%0t: out_prio expected=%h actual=%h", $time, exp.prio, got.prio);
         if (got.payload !== exp.payload)
            $display("%0t: out_payload expected=%h actual=%h", $time, exp.payload,
                     got.payload);
         if (got.pending !== exp.pending)
            $display("%0t: pending expected=%0d actual=%0d", $time, exp.pending,
                     got.pending);
         if (got.last !== exp.last)
            $display("%0t: last expected=%0d actual=%0d", $time, exp.last, got.last);
         if (got !== exp) errors++;
      endfunction
   endclass

   logic clock;
   logic reset;
   longint cycles;
   heap_scoreboard sb;

   temh_req_if req ();
   temh_rsp_if rsp ();

   timed_event_min_heap u_top (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 2000000) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // check results and draw a wait before each one
   initial begin
      int w;
      sb = new();
      rsp.ready = 0;
      w = $urandom_range(0, 17);
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            sb.check_outcome({rsp.kind, rsp.out_time, rsp.out_prio, rsp.out_payload,
                              rsp.pending, rsp.last});
            w = $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
         end
         if (w > 0) begin
            rsp.ready <= 0;
            w--;
         end else begin
            rsp.ready <= 1;
         end
      end
   end

   task automatic send(logic [1:0] cmd, logic [1:0] cnt,
                       logic [31:0] ta, logic [7:0] pa, logic [31:0] da,
                       logic [31:0] tb, logic [7:0] pb, logic [31:0] db,
                       logic [31:0] now);
      int gap;
      gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.cmd <= cmd; req.num_events <= cnt;
      req.time_a <= ta; req.prio_a <= pa; req.payload_a <= da;
      req.time_b <= tb; req.prio_b <= pb; req.payload_b <= db;
      req.now_time <= now;
      do @(posedge clock); while (!req.ready);
      sb.note_request(cmd, cnt, ta, pa, da, tb, pb, db, now);
   endtask

   task automatic push_rand(logic [31:0] base, int span);
      send(CMD_PUSH, 2'($urandom_range(0, 3)),
           base + $urandom_range(0, span),
           ($urandom_range(0, 3) == 0) ? 8'd5 : 8'($urandom),
           $urandom, base + $urandom_range(0, span),
           8'($urandom_range(0, 255)), $urandom, $urandom);
   endtask

   // drop the request and wait until every expected result has come
   task automatic drain();
      req.valid <= 0;
      @(posedge clock);
      while (sb.due_q.size() != 0) @(posedge clock);
   endtask

   logic [31:0] now_base;

   initial begin
      reset = 1;
      req.valid = 0; req.cmd = CMD_NONE; req.num_events = 0;
      req.time_a = 0; req.prio_a = 0; req.payload_a = 0;
      req.time_b = 0; req.prio_b = 0; req.payload_b = 0; req.now_time = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty tick, field extremes, counts 0..3, ties, wrap, unused cmd
      send(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send(CMD_PUSH, 1, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
      send(CMD_PUSH, 2, 32'h0000_0010, 8'h00, 32'h0, 32'h0000_0010, 8'h00, 32'h1, 0);
      send(CMD_PUSH, 3, 32'h0000_0010, 8'h00, 32'h2, 32'h8000_0000, 8'h80, 32'h3, 0);
      send(CMD_PUSH, 0, 32'h5, 8'h1, 32'h4, 32'h6, 8'h2, 32'h5, 0);
      send(CMD_NONE, 2, 32'h5, 8'h1, 32'h4, 32'h6, 8'h2, 32'h5, 32'hFFFF_FFFF);
      send(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFE);
      send(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0010);
      send(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF);
      send(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000);
      // fill to overflow with close times and ties, then drain with one tick
      repeat (33) begin
         send(CMD_PUSH, 2'd2, 32'h1000 + $urandom_range(0, 40),
              8'($urandom_range(0, 3)), $urandom, 32'h1000 + $urandom_range(0, 40),
              8'($urandom_range(0, 3)), $urandom, 0);
      end
      send(CMD_PUSH, 2, 1, 1, 1, 2, 2, 2, 0);
      send(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 32'h2000);
      send(CMD_PUSH, 1, 3, 3, 3, 0, 0, 0, 0);
      send(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);

      // hold the sender until every expected result has come
      drain();

      // random: mostly pushes near a moving time base, ticks that advance
      now_base = $urandom;
      for (int i = 0; i < 75; i++) begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 60) push_rand(now_base, 200);
         else if (r < 92) begin
            now_base = now_base + $urandom_range(0, 120);
            send(CMD_TICK, 2'($urandom), $urandom, 8'($urandom), $urandom, $urandom,
                 8'($urandom), $urandom, now_base);
         end else if (r < 96) send(CMD_CLEAR, 2'($urandom), 0, 0, 0, 0, 0, 0, $urandom);
         else send(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, $urandom);
         if (i == 40) drain();
      end

      drain();
      repeat (500) @(posedge clock);
      if (sb.errors == 0 && sb.due_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- tb/temh_tb_unused.sv -----
`timescale 1ns / 1ps

// ----- timed_event_min_heap.f -----
rtl/temh_pkg.sv
rtl/temh_req_if.sv
rtl/temh_rsp_if.sv
rtl/timed_event_min_heap.sv
rtl/temh_checker.sv
tb/timed_event_min_heap_tb.sv
tb/temh_tb_unused.sv
